FILE: hw/rtl/ktb_pkg.sv
// ----------------------------------------------------------------------------
// ktb_pkg: shared definitions for the keypoint threshold and top-k unit
// Command codes, register indexes, reset values and the control bundle that
// drives the ranked cell chain.
// ----------------------------------------------------------------------------
package ktb_pkg;

    localparam int DEF_KEEP_CAPACITY = 512;
    localparam int DEF_COORD_BITS    = 11;

    localparam int SCORE_W     = 16;
    localparam int MARGIN_W    = 10;
    localparam int DIM_W       = 11;
    localparam int LIMIT_W     = 10;
    localparam int OUT_COORD_W = 11;
    localparam int PASS_W      = 22;
    localparam int ADDR_W      = 5;
    localparam int DATA_W      = 32;

    localparam logic [PASS_W-1:0] PASSED_MAX = {PASS_W{1'b1}};

    localparam logic [1:0] CMD_FRAME  = 2'd0;
    localparam logic [1:0] CMD_SAMPLE = 2'd1;
    localparam logic [1:0] CMD_FETCH  = 2'd2;
    localparam logic [1:0] CMD_NONE   = 2'd3;

    localparam logic [2:0] REG_THRESHOLD = 3'd0;
    localparam logic [2:0] REG_MARGIN    = 3'd1;
    localparam logic [2:0] REG_WIDTH     = 3'd2;
    localparam logic [2:0] REG_HEIGHT    = 3'd3;
    localparam logic [2:0] REG_LIMIT     = 3'd4;

    localparam logic [SCORE_W-1:0]  RST_THRESHOLD = 16'd328;
    localparam logic [MARGIN_W-1:0] RST_MARGIN    = 10'd4;
    localparam logic [DIM_W-1:0]    RST_WIDTH     = 11'd640;
    localparam logic [DIM_W-1:0]    RST_HEIGHT    = 11'd480;
    localparam logic [LIMIT_W-1:0]  RST_LIMIT     = 10'd512;

    typedef struct packed {
        logic clear;
        logic insert;
        logic load_taps;
        logic shift_taps;
    } chain_ctl_t;

endpackage

FILE: hw/rtl/ktb_cell.sv
// ----------------------------------------------------------------------------
// ktb_cell: one slot of the ranked keypoint chain
// Holds one entry, takes part in the sorted shift insert, and carries one tap
// of the readout shift line.
// ----------------------------------------------------------------------------
module ktb_cell
    import ktb_pkg::*;
#(
    parameter int ENTRY_W = 2 * DEF_COORD_BITS + SCORE_W
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  chain_ctl_t         ctl,
    input  logic [ENTRY_W-1:0] new_entry,
    input  logic [ENTRY_W-1:0] prev_entry,
    input  logic               prev_occ,
    input  logic               prev_keep,
    input  logic [ENTRY_W-1:0] next_tap,
    output logic [ENTRY_W-1:0] entry,
    output logic               occ,
    output logic               keep,
    output logic [ENTRY_W-1:0] tap
);

    logic [ENTRY_W-1:0] entry_reg;
    logic               occ_reg;
    logic [ENTRY_W-1:0] tap_reg;

    // An occupied slot with an equal or higher score stays ahead of the new one.
    assign keep  = occ_reg && (entry_reg[SCORE_W-1:0] >= new_entry[SCORE_W-1:0]);
    assign entry = entry_reg;
    assign occ   = occ_reg;
    assign tap   = tap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else if (ctl.clear)
        begin
            occ_reg <= 1'b0;
        end
        else if (ctl.insert && !keep)
        begin
            occ_reg <= prev_keep ? 1'b1 : prev_occ;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.insert && !keep)
        begin
            entry_reg <= prev_keep ? new_entry : prev_entry;
        end
        if (ctl.load_taps)
        begin
            tap_reg <= entry_reg;
        end
        else if (ctl.shift_taps)
        begin
            tap_reg <= next_tap;
        end
    end

endmodule

FILE: hw/rtl/ktb_rank_chain.sv
// ----------------------------------------------------------------------------
// ktb_rank_chain: row of ranked cells
// Keeps the best entries sorted by descending score and shifts a copy out
// toward the head for readout.
// ----------------------------------------------------------------------------
module ktb_rank_chain
    import ktb_pkg::*;
#(
    parameter int KEEP_CAPACITY = DEF_KEEP_CAPACITY,
    parameter int ENTRY_W       = 2 * DEF_COORD_BITS + SCORE_W
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  chain_ctl_t         ctl,
    input  logic [ENTRY_W-1:0] new_entry,
    output logic [ENTRY_W-1:0] head_tap
);

    logic [ENTRY_W-1:0] ent  [KEEP_CAPACITY];
    logic               occ  [KEEP_CAPACITY];
    logic               keep [KEEP_CAPACITY];
    logic [ENTRY_W-1:0] tap  [KEEP_CAPACITY];

    genvar i;
    generate
        for (i = 0; i < KEEP_CAPACITY; i++)
        begin : g_cell
            logic [ENTRY_W-1:0] prev_e;
            logic               prev_o;
            logic               prev_k;
            logic [ENTRY_W-1:0] next_t;

            if (i == 0)
            begin : g_head
                assign prev_e = '0;
                assign prev_o = 1'b0;
                assign prev_k = 1'b1;
            end
            else
            begin : g_body
                assign prev_e = ent[i-1];
                assign prev_o = occ[i-1];
                assign prev_k = keep[i-1];
            end

            if (i == KEEP_CAPACITY - 1)
            begin : g_tail
                assign next_t = '0;
            end
            else
            begin : g_link
                assign next_t = tap[i+1];
            end

            ktb_cell #(
                .ENTRY_W (ENTRY_W)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl),
                .new_entry  (new_entry),
                .prev_entry (prev_e),
                .prev_occ   (prev_o),
                .prev_keep  (prev_k),
                .next_tap   (next_t),
                .entry      (ent[i]),
                .occ        (occ[i]),
                .keep       (keep[i]),
                .tap        (tap[i])
            );
        end
    endgenerate

    assign head_tap = tap[0];

endmodule

FILE: hw/rtl/ktb_arrival_mem.sv
// ----------------------------------------------------------------------------
// ktb_arrival_mem: arrival order store
// One write port and one registered read port.
// ----------------------------------------------------------------------------
module ktb_arrival_mem
    import ktb_pkg::*;
#(
    parameter int KEEP_CAPACITY = DEF_KEEP_CAPACITY,
    parameter int ENTRY_W       = 2 * DEF_COORD_BITS + SCORE_W,
    parameter int AW            = $clog2(KEEP_CAPACITY)
)
(
    input  logic               clk,
    input  logic               wr_en,
    input  logic [AW-1:0]      wr_addr,
    input  logic [ENTRY_W-1:0] wr_data,
    input  logic               rd_en,
    input  logic [AW-1:0]      rd_addr,
    output logic [ENTRY_W-1:0] rd_data
);

    logic [ENTRY_W-1:0] mem [KEEP_CAPACITY];
    logic [ENTRY_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/keypoint_threshold_border_topk_unit.sv
// ----------------------------------------------------------------------------
// keypoint_threshold_border_topk_unit: score threshold, border filter, top-k
// Filters a raster score map and reads out the kept keypoints on demand.
// ----------------------------------------------------------------------------
// Frame start and score sample transactions do not raise busy, so samples
// may be issued back to back. A passing sample is inserted into the ranked
// cell chain and, while fewer than KEEP_CAPACITY points have passed, written
// to the arrival store. A fetch raises busy, passes through ST_SEEK and
// returns its registered result, marked by a one-cycle done strobe. When
// more points passed than the limit, the ranked chain copies itself into its
// readout shift line and in ST_SEEK shifts it toward the head once per
// already fetched point; the result is then taken from the head. Results
// cannot be held off: the receiver must take done when it comes. A new
// transaction may be started in the cycle that done is shown. Registers are
// to be written through the APB port only while the unit is idle; the user
// must keep to this, as the unit does not enforce it. A limit above
// KEEP_CAPACITY, including all ones, means KEEP_CAPACITY.
// ----------------------------------------------------------------------------
module keypoint_threshold_border_topk_unit
    import ktb_pkg::*;
#(
    parameter int KEEP_CAPACITY = DEF_KEEP_CAPACITY,
    parameter int COORD_BITS    = DEF_COORD_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [1:0]             command,
    input  logic [SCORE_W-1:0]     score,
    output logic                   done,
    output logic [OUT_COORD_W-1:0] keypoint_x,
    output logic [OUT_COORD_W-1:0] keypoint_y,
    output logic [SCORE_W-1:0]     keypoint_score,
    output logic                   valid_res,
    output logic                   last,
    output logic                   truncated,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [ADDR_W-1:0]      paddr,
    input  logic [DATA_W-1:0]      pwdata,
    output logic [DATA_W-1:0]      prdata,
    output logic                   pready
);

    localparam int ENTRY_W = 2 * COORD_BITS + SCORE_W;
    localparam int AW      = $clog2(KEEP_CAPACITY);
    localparam int CNT_W   = AW + 1;
    localparam int CMP_W   = ((COORD_BITS > DIM_W) ? COORD_BITS : DIM_W) + 2;
    localparam logic [PASS_W-1:0]     CAP_P     = PASS_W'(KEEP_CAPACITY);
    localparam logic [COORD_BITS-1:0] COORD_MAX = {COORD_BITS{1'b1}};

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_SEEK
    } state_t;

    // Configuration registers.
    logic [SCORE_W-1:0]  threshold_reg;
    logic [MARGIN_W-1:0] margin_reg;
    logic [DIM_W-1:0]    width_reg;
    logic [DIM_W-1:0]    height_reg;
    logic [LIMIT_W-1:0]  limit_reg;

    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= RST_THRESHOLD;
            margin_reg    <= RST_MARGIN;
            width_reg     <= RST_WIDTH;
            height_reg    <= RST_HEIGHT;
            limit_reg     <= RST_LIMIT;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[4:2])
                REG_THRESHOLD: threshold_reg <= pwdata[SCORE_W-1:0];
                REG_MARGIN:    margin_reg    <= pwdata[MARGIN_W-1:0];
                REG_WIDTH:     width_reg     <= pwdata[DIM_W-1:0];
                REG_HEIGHT:    height_reg    <= pwdata[DIM_W-1:0];
                REG_LIMIT:     limit_reg     <= pwdata[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            REG_THRESHOLD: prdata = DATA_W'(threshold_reg);
            REG_MARGIN:    prdata = DATA_W'(margin_reg);
            REG_WIDTH:     prdata = DATA_W'(width_reg);
            REG_HEIGHT:    prdata = DATA_W'(height_reg);
            REG_LIMIT:     prdata = DATA_W'(limit_reg);
            default:       prdata = '0;
        endcase
    end

    // Transaction decode.
    state_t state_reg, state_next;
    logic   accept;
    logic   do_frame, do_sample, do_fetch;

    assign busy      = (state_reg != ST_IDLE);
    assign accept    = start && !busy;
    assign do_frame  = accept && (command == CMD_FRAME);
    assign do_sample = accept && (command == CMD_SAMPLE);
    assign do_fetch  = accept && (command == CMD_FETCH);

    // Raster position and the pass test.
    logic [COORD_BITS-1:0] col_reg, col_next;
    logic [COORD_BITS-1:0] row_reg, row_next;
    logic [PASS_W-1:0]     passed_reg, passed_next;
    logic [CNT_W-1:0]      rpos_reg, rpos_next;
    logic [CMP_W-1:0]      c_ext, r_ext, m_ext, w_ext, h_ext;
    logic                  pass;
    logic [ENTRY_W-1:0]    new_entry;

    assign c_ext = CMP_W'(col_reg);
    assign r_ext = CMP_W'(row_reg);
    assign m_ext = CMP_W'(margin_reg);
    assign w_ext = CMP_W'(width_reg);
    assign h_ext = CMP_W'(height_reg);

    assign pass = (score > threshold_reg)
        && (c_ext >= m_ext) && (c_ext + m_ext < w_ext)
        && (r_ext >= m_ext) && (r_ext + m_ext < h_ext);

    assign new_entry = {col_reg, row_reg, score};

    // Limit, truncation and availability as seen by a fetch.
    logic [PASS_W-1:0] limit_ext, limit_eff, avail;
    logic [PASS_W-1:0] rpos_ext;
    logic              trunc_now, valid_now, last_now;

    assign limit_ext = PASS_W'(limit_reg);
    assign limit_eff = (limit_ext > CAP_P) ? CAP_P : limit_ext;
    assign trunc_now = passed_reg > limit_eff;
    assign avail     = trunc_now ? limit_eff : passed_reg;
    assign rpos_ext  = PASS_W'(rpos_reg);
    assign valid_now = rpos_ext < avail;
    assign last_now  = (rpos_ext + PASS_W'(1)) == avail;

    always_comb
    begin
        col_next    = col_reg;
        row_next    = row_reg;
        passed_next = passed_reg;
        rpos_next   = rpos_reg;
        if (do_frame)
        begin
            col_next    = '0;
            row_next    = '0;
            passed_next = '0;
            rpos_next   = '0;
        end
        else if (do_sample)
        begin
            if (pass && (passed_reg != PASSED_MAX))
            begin
                passed_next = passed_reg + PASS_W'(1);
            end
            // A zero width ends every row at once, so the column stays zero.
            if (c_ext + CMP_W'(1) >= w_ext)
            begin
                col_next = '0;
                if (row_reg != COORD_MAX)
                begin
                    row_next = row_reg + COORD_BITS'(1);
                end
            end
            else
            begin
                col_next = COORD_BITS'(c_ext + CMP_W'(1));
            end
        end
        else if (do_fetch && valid_now)
        begin
            rpos_next = rpos_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg    <= '0;
            row_reg    <= '0;
            passed_reg <= '0;
            rpos_reg   <= '0;
        end
        else
        begin
            col_reg    <= col_next;
            row_reg    <= row_next;
            passed_reg <= passed_next;
            rpos_reg   <= rpos_next;
        end
    end

    // Stores.
    chain_ctl_t         ctl;
    logic [ENTRY_W-1:0] head_tap;
    logic [ENTRY_W-1:0] arr_data;
    logic [AW-1:0]      seek_reg, seek_next;

    assign ctl.clear      = do_frame;
    assign ctl.insert     = do_sample && pass;
    assign ctl.load_taps  = do_fetch;
    assign ctl.shift_taps = (state_reg == ST_SEEK) && (seek_reg != '0);

    ktb_rank_chain #(
        .KEEP_CAPACITY (KEEP_CAPACITY),
        .ENTRY_W       (ENTRY_W)
    ) u_rank (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .new_entry (new_entry),
        .head_tap  (head_tap)
    );

    ktb_arrival_mem #(
        .KEEP_CAPACITY (KEEP_CAPACITY),
        .ENTRY_W       (ENTRY_W),
        .AW            (AW)
    ) u_arrival (
        .clk     (clk),
        .wr_en   (do_sample && pass && (passed_reg < CAP_P)),
        .wr_addr (passed_reg[AW-1:0]),
        .wr_data (new_entry),
        .rd_en   (do_fetch),
        .rd_addr (rpos_reg[AW-1:0]),
        .rd_data (arr_data)
    );

    // Fetch sequencer and result registers.
    logic                   trunc_reg, trunc_next;
    logic                   valid_reg, valid_next;
    logic                   lastq_reg, lastq_next;
    logic                   done_reg, done_next;
    logic [OUT_COORD_W-1:0] x_reg, x_next;
    logic [OUT_COORD_W-1:0] y_reg, y_next;
    logic [SCORE_W-1:0]     s_reg, s_next;
    logic                   vres_reg, vres_next;
    logic                   lres_reg, lres_next;
    logic                   tres_reg, tres_next;
    logic [ENTRY_W-1:0]     pick;

    assign pick = trunc_reg ? head_tap : arr_data;

    always_comb
    begin
        state_next = state_reg;
        seek_next  = seek_reg;
        trunc_next = trunc_reg;
        valid_next = valid_reg;
        lastq_next = lastq_reg;
        done_next  = 1'b0;
        x_next     = x_reg;
        y_next     = y_reg;
        s_next     = s_reg;
        vres_next  = vres_reg;
        lres_next  = lres_reg;
        tres_next  = tres_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (do_fetch)
                begin
                    state_next = ST_SEEK;
                    trunc_next = trunc_now;
                    valid_next = valid_now;
                    lastq_next = valid_now && last_now;
                    seek_next  = (trunc_now && valid_now) ? rpos_reg[AW-1:0] : '0;
                end
            end
            ST_SEEK:
            begin
                if (seek_reg == '0)
                begin
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                    tres_next  = trunc_reg;
                    vres_next  = valid_reg;
                    lres_next  = lastq_reg;
                    if (valid_reg)
                    begin
                        x_next = OUT_COORD_W'(pick[ENTRY_W-1 -: COORD_BITS]);
                        y_next = OUT_COORD_W'(pick[SCORE_W +: COORD_BITS]);
                        s_next = pick[SCORE_W-1:0];
                    end
                    else
                    begin
                        x_next = '0;
                        y_next = '0;
                        s_next = '0;
                    end
                end
                else
                begin
                    seek_next = seek_reg - AW'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            seek_reg  <= '0;
            trunc_reg <= 1'b0;
            valid_reg <= 1'b0;
            lastq_reg <= 1'b0;
            done_reg  <= 1'b0;
            x_reg     <= '0;
            y_reg     <= '0;
            s_reg     <= '0;
            vres_reg  <= 1'b0;
            lres_reg  <= 1'b0;
            tres_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            seek_reg  <= seek_next;
            trunc_reg <= trunc_next;
            valid_reg <= valid_next;
            lastq_reg <= lastq_next;
            done_reg  <= done_next;
            x_reg     <= x_next;
            y_reg     <= y_next;
            s_reg     <= s_next;
            vres_reg  <= vres_next;
            lres_reg  <= lres_next;
            tres_reg  <= tres_next;
        end
    end

    assign done           = done_reg;
    assign keypoint_x     = x_reg;
    assign keypoint_y     = y_reg;
    assign keypoint_score = s_reg;
    assign valid_res      = vres_reg;
    assign last           = lres_reg;
    assign truncated      = tres_reg;

endmodule

FILE: hw/rtl/ktb_checker.sv
// ----------------------------------------------------------------------------
// ktb_checker: port-level checks for the keypoint top-k unit
// Watches the command and result ports over time.
// ----------------------------------------------------------------------------
module ktb_checker
    import ktb_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic                   busy,
    input  logic [1:0]             command,
    input  logic                   done,
    input  logic [OUT_COORD_W-1:0] keypoint_x,
    input  logic [OUT_COORD_W-1:0] keypoint_y,
    input  logic [SCORE_W-1:0]     keypoint_score,
    input  logic                   valid_res,
    input  logic                   last,
    input  logic                   pready
);

    // An accepted fetch always makes the unit busy.
    a_fetch_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && command == CMD_FETCH) |=> busy)
        else $error("fetch accepted without going busy");

    // A done strobe is never followed directly by another.
    a_done_gap: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("two results in consecutive cycles");

    // An empty fetch reports zero coordinates and score.
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !valid_res) |->
            (keypoint_x == '0 && keypoint_y == '0 && keypoint_score == '0 && !last))
        else $error("empty fetch carries a payload");

    // A result only follows a transaction that made the unit busy.
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without a preceding fetch");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready dropped");

endmodule

bind keypoint_threshold_border_topk_unit ktb_checker u_ktb_checker (.*);
